FILE: design/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Types and constants that the capture record deframer modules share.
// ----------------------------------------------------------------------------
package crd_pkg;

    // Header layout: seconds, nanoseconds, captured length, wire length.
    localparam int unsigned HDR_BYTES = 12;
    localparam logic [3:0]  HDR_LAST  = 4'(HDR_BYTES - 1);

    // Nanoseconds in one second; it fits in 30 bits.
    localparam int unsigned NS_W       = 30;
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    // Timestamp width: 32-bit seconds times a 30-bit constant.
    localparam int unsigned TS_W = 62;

    // Packed width of the result data word, rounded up to whole bytes.
    localparam int unsigned DATA_BITS = 32 + 32 + 16 + 16 + TS_W + 1 + 8;
    localparam int unsigned TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    // Result kinds.
    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } crd_kind_t;

    // One result item.
    typedef struct packed {
        crd_kind_t         kind;
        logic [31:0]       seconds;
        logic [31:0]       nanoseconds;
        logic [15:0]       cap_len;
        logic [15:0]       wire_len;
        logic [TS_W-1:0]   timestamp_ns;
        logic              is_padding;
        logic [7:0]        data_byte;
        logic              last;
    } crd_result_t;

endpackage

FILE: design/crd_parser.sv
// ----------------------------------------------------------------------------
// crd_parser
// Record state tracker: assembles the header, counts the captured bytes and
// forms at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module crd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_fire,
    input  logic [7:0]           byte_in,
    output logic                 res_valid,
    output crd_pkg::crd_result_t res
);
    import crd_pkg::*;

    logic [3:0]      header_index_reg, header_index_next;
    logic [31:0]     seconds_reg;
    logic [31:0]     nanos_reg;
    logic [15:0]     caplen_reg;
    logic [15:0]     wirelen_reg;
    logic [15:0]     bytes_left_reg, bytes_left_next;
    logic            in_data_reg, in_data_next;
    logic            skipping_reg, skipping_next;
    logic [TS_W-1:0] product_reg;

    logic            pad;
    logic            data_last;
    logic [15:0]     wire_len_full;

    // The seconds field is complete eight bytes before the header ends, so the
    // product registered from it is settled long before it is needed.
    always_ff @(posedge aclk) begin
        product_reg <= TS_W'(seconds_reg) * TS_W'(NS_PER_SEC);
    end

    // Header fields are assembled byte by byte, least significant first.
    always_ff @(posedge aclk) begin
        if (byte_fire && !in_data_reg) begin
            if (header_index_reg < 4'd4) begin
                seconds_reg[8*header_index_reg[1:0] +: 8] <= byte_in;
            end else if (header_index_reg < 4'd8) begin
                nanos_reg[8*header_index_reg[1:0] +: 8] <= byte_in;
            end else if (header_index_reg < 4'd10) begin
                caplen_reg[8*header_index_reg[0] +: 8] <= byte_in;
            end else begin
                wirelen_reg[8*header_index_reg[0] +: 8] <= byte_in;
            end
        end
    end

    assign pad           = (seconds_reg == 32'd0) && (nanos_reg == 32'd0);
    assign data_last     = (bytes_left_reg == 16'd1);
    assign wire_len_full = {byte_in, wirelen_reg[7:0]};

    // Next state and the result for the byte on the input.
    always_comb begin
        header_index_next = header_index_reg;
        bytes_left_next   = bytes_left_reg;
        in_data_next      = in_data_reg;
        skipping_next     = skipping_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (in_data_reg) begin
            // Captured byte: passed on unless the record is padding.
            bytes_left_next = bytes_left_reg - 16'd1;
            if (data_last) begin
                in_data_next  = 1'b0;
                skipping_next = 1'b0;
            end
            if (!skipping_reg) begin
                res_valid     = byte_fire;
                res.kind      = KIND_DATA;
                res.data_byte = byte_in;
                res.last      = data_last;
            end
        end else if (header_index_reg != HDR_LAST) begin
            header_index_next = header_index_reg + 4'd1;
        end else begin
            // Final header byte: emit the header result.
            header_index_next = '0;
            bytes_left_next   = caplen_reg;
            in_data_next      = (caplen_reg != 16'd0);
            skipping_next     = pad && (caplen_reg != 16'd0);
            res_valid         = byte_fire;
            res.kind          = KIND_HEADER;
            res.seconds       = seconds_reg;
            res.nanoseconds   = nanos_reg;
            res.cap_len       = caplen_reg;
            res.wire_len      = wire_len_full;
            res.timestamp_ns  = product_reg + TS_W'(nanos_reg);
            res.is_padding    = pad;
            res.last          = !pad && (caplen_reg == 16'd0);
        end
    end

    // Control state advances on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_index_reg <= '0;
            bytes_left_reg   <= '0;
            in_data_reg      <= 1'b0;
            skipping_reg     <= 1'b0;
        end else if (byte_fire) begin
            header_index_reg <= header_index_next;
            bytes_left_reg   <= bytes_left_next;
            in_data_reg      <= in_data_next;
            skipping_reg     <= skipping_next;
        end
    end

    // The header counter never runs past the last header byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        header_index_reg <= HDR_LAST)
        else $error("header index beyond header length");

    // Data is counted only when bytes remain, and the counter rests at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_data_reg == (bytes_left_reg != 16'd0))
        else $error("data phase and byte count disagree");

    // Skipping only happens inside the data phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skipping_reg |-> in_data_reg)
        else $error("padding skip outside data phase");

    // Header bytes are never consumed while data bytes remain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_data_reg |-> header_index_reg == 4'd0)
        else $error("header counter moved during data phase");

endmodule

FILE: design/capture_record_deframer.sv
// ----------------------------------------------------------------------------
// capture_record_deframer
// Splits a capture buffer byte stream into header and data results.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while s_tready is high and registers
// its result for that byte in the output or skid register. Each record is a
// 12-byte little-endian header followed by its captured bytes; the twelfth
// header byte yields a header result with the 62-bit timestamp in
// nanoseconds, and each captured byte yields a data result, the last one
// flagged on tlast. Padding records (zero seconds and nanoseconds) give only a
// flagged header result. The seconds-times-one-billion product is registered
// off the assembled seconds field, and a two-entry output buffer (output
// register plus skid register) takes one more result behind a stalled full
// output register; s_tready drops only while both entries are full.
module capture_record_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input byte stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] byte_in
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] seconds, [63:32] nanoseconds, [79:64] cap_len, [95:80] wire_len,
    // [157:96] timestamp_ns, [158] is_padding, [166:159] data_byte, [167] zero
    output logic [crd_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser,   // [0] kind
    output logic                         m_tlast    // last
);
    import crd_pkg::*;

    logic        s_fire;
    logic        m_fire;
    logic        res_valid;
    crd_result_t res;

    logic        out_valid_reg;
    crd_result_t out_reg;
    logic        skid_valid_reg;
    crd_result_t skid_reg;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    crd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (s_fire),
        .byte_in   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register and skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (res_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    // Pack the result onto the stream ports.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{(TDATA_W - DATA_BITS){1'b0}},
                       out_reg.data_byte,
                       out_reg.is_padding,
                       out_reg.timestamp_ns,
                       out_reg.wire_len,
                       out_reg.cap_len,
                       out_reg.nanoseconds,
                       out_reg.seconds};

    // The skid entry is only ever filled behind a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    // A result arriving at a stalled full output lands in the skid entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("result lost at stalled output");

    // A result is formed only for an accepted byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> s_fire)
        else $error("result without accepted byte");

endmodule

FILE: sim/tb_capture_record_deframer.sv
// ----------------------------------------------------------------------------
// tb_capture_record_deframer
// Self-checking testbench for the capture record deframer. A short table of
// hand-picked records comes first. Random records follow, with bursts and
// stalls on both sides. Every accepted result item is compared field by field
// with the table's expected result or else with a behavioural model's output.
// ----------------------------------------------------------------------------
module tb_capture_record_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import crd_pkg::*;

    localparam longint unsigned NANOS_PER_SECOND = 64'd1_000_000_000;
    localparam logic [3:0]      FINAL_HDR_POS    = 4'd11;
    localparam int unsigned     RANDOM_ITEMS     = 1100;
    localparam int unsigned     DRAIN_CYCLES     = 8;

    // One row of the directed table; fixed holds the expected result when typed.
    typedef struct packed {
        logic [7:0]  value;
        logic        typed;
        crd_result_t fixed;
    } feed_item_t;

    localparam crd_result_t NO_RESULT = '0;

    // Largest seconds and nanoseconds with no captured bytes: an empty record.
    localparam crd_result_t EXTREME_HDR = '{
        kind: KIND_HEADER, seconds: 32'hFFFF_FFFF, nanoseconds: 32'hFFFF_FFFF,
        cap_len: 16'h0000, wire_len: 16'hFFFF,
        timestamp_ns: 62'd4294967299294967295,
        is_padding: 1'b0, data_byte: 8'h00, last: 1'b1
    };

    // Padding record holding one byte, which is dropped without a result.
    localparam crd_result_t PADDING_HDR = '{
        kind: KIND_HEADER, seconds: 32'h0, nanoseconds: 32'h0,
        cap_len: 16'h0001, wire_len: 16'h0000, timestamp_ns: 62'd0,
        is_padding: 1'b1, data_byte: 8'h00, last: 1'b0
    };

    localparam feed_item_t DIRECTED [25] = '{
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b1, EXTREME_HDR},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b1, PADDING_HDR},
        '{8'hFF, 1'b0, NO_RESULT}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Bytes still to be offered, and the result items that they have caused.
    feed_item_t  byte_feed[$];
    crd_result_t awaited_results[$];
    feed_item_t  offered;
    int unsigned error_count = 0;

    // Deframer model state.
    logic [3:0]  hdr_pos;
    logic [31:0] sec_acc;
    logic [31:0] ns_acc;
    logic [15:0] caplen_acc;
    logic [15:0] wirelen_acc;
    logic [15:0] bytes_remaining;
    logic        in_payload;
    logic        dropping_pad;

    // Traffic shaping.
    bit          calm = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;

    capture_record_deframer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Prints one line per failure and keeps count.
    task automatic report_fail(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_fail($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Most gaps are short, a few are long, and none fall in a calm stretch.
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Advances the deframer model by one byte and gives the result it causes.
    task automatic deframe_step(input logic [7:0] b, output bit produced,
                                output crd_result_t res);
        int unsigned lane;
        bit          pad;
        res      = '0;
        produced = 1'b0;
        lane     = hdr_pos;
        if (in_payload) begin
            bytes_remaining = bytes_remaining - 16'd1;
            if (bytes_remaining == 16'd0)
                in_payload = 1'b0;
            if (dropping_pad) begin
                if (bytes_remaining == 16'd0)
                    dropping_pad = 1'b0;
            end else begin
                produced      = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = b;
                res.last      = (bytes_remaining == 16'd0);
            end
        end else begin
            // Little-endian assembly of the four header fields.
            if (lane < 4)
                sec_acc[8*lane +: 8] = b;
            else if (lane < 8)
                ns_acc[8*(lane-4) +: 8] = b;
            else if (lane < 10)
                caplen_acc[8*(lane-8) +: 8] = b;
            else
                wirelen_acc[8*(lane-10) +: 8] = b;

            if (hdr_pos != FINAL_HDR_POS) begin
                hdr_pos = hdr_pos + 4'd1;
            end else begin
                hdr_pos         = 4'd0;
                pad             = (sec_acc == 32'd0) && (ns_acc == 32'd0);
                bytes_remaining = caplen_acc;
                in_payload      = (caplen_acc != 16'd0);
                dropping_pad    = pad && in_payload;
                produced        = 1'b1;
                res.kind        = KIND_HEADER;
                res.seconds     = sec_acc;
                res.nanoseconds = ns_acc;
                res.cap_len     = caplen_acc;
                res.wire_len    = wirelen_acc;
                res.timestamp_ns = TS_W'(64'(sec_acc) * NANOS_PER_SECOND + 64'(ns_acc));
                res.is_padding  = pad;
                res.last        = !pad && (caplen_acc == 16'd0);
            end
        end
    endtask

    // Appends one record and returns how many input bytes it adds.
    function automatic int unsigned queue_record(input logic [31:0] sec,
                                                 input logic [31:0] ns,
                                                 input logic [15:0] cap,
                                                 input logic [15:0] wire_len);
        feed_item_t      it;
        logic [95:0]     hdr;
        int unsigned     r;
        it  = '0;
        hdr = {wire_len, cap, ns, sec};
        for (int i = 0; i < 12; i++) begin
            it.value = hdr[8*i +: 8];
            byte_feed.push_back(it);
        end
        for (int i = 0; i < cap; i++) begin
            r = $urandom_range(0, 19);
            it.value = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            byte_feed.push_back(it);
        end
        return 12 + int'(cap);
    endfunction

    // Drives both channels, runs the model on accepted bytes and checks results.
    always @(posedge aclk) begin : traffic
        bit          next_valid;
        logic [7:0]  next_data;
        bit          produced;
        crd_result_t predicted;
        crd_result_t got;
        crd_result_t want;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 299) == 0)
                calm = !calm;

            // Input side: an accepted byte updates the model.
            next_valid = s_tvalid;
            next_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                deframe_step(offered.value, produced, predicted);
                if (offered.typed)
                    awaited_results.push_back(offered.fixed);
                else if (produced)
                    awaited_results.push_back(predicted);
                next_valid = 1'b0;
                in_gap     = pick_gap(calm);
            end
            if (!next_valid) begin
                if (in_gap != 0) begin
                    in_gap--;
                end else if (byte_feed.size() != 0) begin
                    offered    = byte_feed.pop_front();
                    next_valid = 1'b1;
                    next_data  = offered.value;
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;

            // Result side: compare against the oldest awaited item.
            if (m_tvalid && m_tready) begin
                got.kind         = crd_kind_t'(m_tuser);
                got.seconds      = m_tdata[31:0];
                got.nanoseconds  = m_tdata[63:32];
                got.cap_len      = m_tdata[79:64];
                got.wire_len     = m_tdata[95:80];
                got.timestamp_ns = m_tdata[157:96];
                got.is_padding   = m_tdata[158];
                got.data_byte    = m_tdata[166:159];
                got.last         = m_tlast;
                if (awaited_results.size() == 0) begin
                    report_fail("result item with none awaited");
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", 64'(got.kind), 64'(want.kind));
                    check_field("seconds", 64'(got.seconds), 64'(want.seconds));
                    check_field("nanoseconds", 64'(got.nanoseconds),
                                64'(want.nanoseconds));
                    check_field("cap_len", 64'(got.cap_len), 64'(want.cap_len));
                    check_field("wire_len", 64'(got.wire_len), 64'(want.wire_len));
                    check_field("timestamp_ns", 64'(got.timestamp_ns),
                                64'(want.timestamp_ns));
                    check_field("is_padding", 64'(got.is_padding), 64'(want.is_padding));
                    check_field("data_byte", 64'(got.data_byte), 64'(want.data_byte));
                    check_field("last", 64'(got.last), 64'(want.last));
                end
            end
            if (out_stall != 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0)
                    out_stall = pick_gap(1'b0);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : main
        int unsigned counted;
        int unsigned r;
        bit          big_pad_done;
        logic [31:0] sec;
        logic [31:0] ns;
        logic [15:0] cap;
        counted      = 0;
        big_pad_done = 1'b0;
        hdr_pos         = '0;
        sec_acc         = '0;
        ns_acc          = '0;
        caplen_acc      = '0;
        wirelen_acc     = '0;
        bytes_remaining = '0;
        in_payload      = 1'b0;
        dropping_pad    = 1'b0;
        offered         = '0;

        foreach (DIRECTED[i])
            byte_feed.push_back(DIRECTED[i]);

        // Random records, with one long padding record halfway.
        while (counted < RANDOM_ITEMS) begin
            if (!big_pad_done && counted > RANDOM_ITEMS / 2) begin
                counted += queue_record(32'd0, 32'd0, 16'd300, 16'($urandom));
                big_pad_done = 1'b1;
            end
            r   = $urandom_range(0, 9);
            sec = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            r   = $urandom_range(0, 9);
            ns  = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
                  (r == 2) ? 32'd999_999_999 : 32'($urandom);
            if ($urandom_range(0, 99) < 15) begin
                sec = 32'd0;
                ns  = 32'd0;
            end
            r   = $urandom_range(0, 99);
            cap = (r < 20) ? 16'd0 : (r < 85) ? 16'($urandom_range(1, 16)) :
                  16'($urandom_range(17, 64));
            counted += queue_record(sec, ns, cap, 16'($urandom));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_feed.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (awaited_results.size() != 0)
            report_fail($sformatf("%0d result items never arrived",
                                  awaited_results.size()));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
